// File: hw/rtl/psp_pkg.sv
// Package for the perspective screen projection block.
// Holds register codes, reset values, fixed field widths and the side-band type.
// No dependencies.
package psp_pkg;

   localparam int FS_W      = 16;
   localparam int SIZE_W    = 13;
   localparam int K_W       = FS_W + SIZE_W;
   localparam int FRAC_BITS = 10;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_SCALE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd2;

   localparam logic [FS_W-1:0]   FOCAL_SCALE_RESET   = 16'd724;
   localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic              dneg;
      logic              negx;
      logic              negy;
      logic [SIZE_W-2:0] cx;
      logic [SIZE_W-2:0] cy;
   } side_type;

endpackage

// File: hw/rtl/perspective_screen_projection.sv
// Perspective screen projection: an accepted word passes stage 1, stage 2, the
// divider stages and the output register before its result word appears.
// Throughput is one word per cycle; the restoring divider has one register stage
// per quotient bit, and every stage holds when the output word is not taken.
// Synchronous active-high reset clears valid bits and loads register defaults.
// Depends on psp_pkg.
module perspective_screen_projection #(
   parameter int COORD_WIDTH       = 32,
   parameter int SCREEN_WIDTH_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [COORD_WIDTH-1:0]        req_point_depth,
   input  logic signed [COORD_WIDTH-1:0]        req_point_horizontal,
   input  logic signed [COORD_WIDTH-1:0]        req_point_vertical,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SCREEN_WIDTH_BITS-1:0]  rsp_screen_x,
   output logic signed [SCREEN_WIDTH_BITS-1:0]  rsp_screen_y,
   output logic                                 rsp_in_front,
   output logic                                 rsp_clipped,
   input  logic                                 csr_we,
   input  logic [psp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psp_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int CW   = COORD_WIDTH;
   localparam int SWB  = SCREEN_WIDTH_BITS;
   localparam int KW   = psp_pkg::K_W;
   localparam int NW   = CW + KW;
   localparam int DW   = CW + psp_pkg::FRAC_BITS;
   localparam int QB   = SWB + 2;
   localparam int CMPW = (NW > DW + QB) ? NW : DW + QB;
   localparam int VW   = QB + 2;
   localparam int SW   = psp_pkg::SIZE_W;
   localparam logic signed [VW-1:0] MAXV = (VW'(1) <<< (SWB - 1)) - VW'(1);
   localparam logic signed [VW-1:0] MINV = -MAXV - VW'(1);

   logic [psp_pkg::FS_W-1:0] focal_scale_ff;
   logic [SW-1:0]            screen_width_ff;
   logic [SW-1:0]            screen_height_ff;

   logic en;

   psp_pkg::side_type side1_in, side1_ff;
   logic [CW-1:0]     dmag1_in, dmag1_ff, lmx1_in, lmx1_ff, lmy1_in, lmy1_ff;
   logic [KW-1:0]     kx1_in, kx1_ff, ky1_in, ky1_ff;

   psp_pkg::side_type side_d_ff [0:QB];
   logic [DW-1:0]     den_d_ff  [0:QB];
   logic [NW-1:0]     remx_d_ff [0:QB];
   logic [NW-1:0]     remy_d_ff [0:QB];
   logic [QB-1:0]     qx_d_ff   [0:QB];
   logic [QB-1:0]     qy_d_ff   [0:QB];

   logic                        rsp_valid_ff;
   logic signed [SWB-1:0]       rsp_x_in, rsp_x_ff, rsp_y_in, rsp_y_ff;
   logic                        rsp_front_in, rsp_front_ff, rsp_clip_in, rsp_clip_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_scale_ff   <= psp_pkg::FOCAL_SCALE_RESET;
         screen_width_ff  <= psp_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= psp_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            psp_pkg::CSR_FOCAL_SCALE:   focal_scale_ff   <= csr_wdata;
            psp_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[SW-1:0];
            psp_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // Stage 1: magnitudes, signs and the scale products.
   always_comb begin
      side1_in.valid = req_valid && req_ready;
      side1_in.dneg  = req_point_depth[CW-1];
      side1_in.negx  = req_point_horizontal[CW-1];
      side1_in.negy  = req_point_vertical[CW-1];
      dmag1_in = req_point_depth[CW-1] ? CW'(-req_point_depth) : CW'(req_point_depth);
      lmx1_in  = req_point_horizontal[CW-1] ? CW'(-req_point_horizontal)
                                            : CW'(req_point_horizontal);
      lmy1_in  = req_point_vertical[CW-1] ? CW'(-req_point_vertical)
                                          : CW'(req_point_vertical);
      side1_in.zero = (dmag1_in == '0);
      side1_in.cx   = screen_width_ff[SW-1:1];
      side1_in.cy   = screen_height_ff[SW-1:1];
      kx1_in = KW'(focal_scale_ff) * KW'(screen_width_ff);
      ky1_in = KW'(focal_scale_ff) * KW'(screen_height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
      end else if (en) begin
         side1_ff <= side1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dmag1_ff <= dmag1_in;
         lmx1_ff  <= lmx1_in;
         lmy1_ff  <= lmy1_in;
         kx1_ff   <= kx1_in;
         ky1_ff   <= ky1_in;
      end
   end

   // Stage 2: numerators and the scaled divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_d_ff[0] <= '0;
      end else if (en) begin
         side_d_ff[0] <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_d_ff[0]  <= {dmag1_ff, {psp_pkg::FRAC_BITS{1'b0}}};
         remx_d_ff[0] <= NW'(lmx1_ff) * NW'(kx1_ff);
         remy_d_ff[0] <= NW'(lmy1_ff) * NW'(ky1_ff);
         qx_d_ff[0]   <= '0;
         qy_d_ff[0]   <= '0;
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   // A set top bit means the quotient is large enough to saturate either way.
   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int B = QB - 1 - j;
      logic [CMPW-1:0] shifted, remx_ext, remy_ext;
      logic            gx, gy;
      logic [NW-1:0]   remx_nx, remy_nx;
      logic [QB-1:0]   qx_nx, qy_nx;

      always_comb begin
         shifted  = CMPW'(den_d_ff[j]) << B;
         remx_ext = CMPW'(remx_d_ff[j]);
         remy_ext = CMPW'(remy_d_ff[j]);
         gx       = (remx_ext >= shifted);
         gy       = (remy_ext >= shifted);
         remx_nx  = gx ? NW'(remx_ext - shifted) : remx_d_ff[j];
         remy_nx  = gy ? NW'(remy_ext - shifted) : remy_d_ff[j];
         qx_nx    = qx_d_ff[j];
         qy_nx    = qy_d_ff[j];
         qx_nx[B] = gx;
         qy_nx[B] = gy;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_d_ff[j+1] <= '0;
         end else if (en) begin
            side_d_ff[j+1] <= side_d_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_d_ff[j+1]  <= den_d_ff[j];
            remx_d_ff[j+1] <= remx_nx;
            remy_d_ff[j+1] <= remy_nx;
            qx_d_ff[j+1]   <= qx_nx;
            qy_d_ff[j+1]   <= qy_nx;
         end
      end
   end

   // Final stage: sign, screen center, saturation and the zero-depth result.
   logic signed [VW-1:0] qxs, qys, vx, vy;
   logic                 satx, saty;

   always_comb begin
      qxs  = signed'({2'b00, qx_d_ff[QB]});
      qys  = signed'({2'b00, qy_d_ff[QB]});
      vx   = ((side_d_ff[QB].negx ^ side_d_ff[QB].dneg) ? -qxs : qxs)
             + signed'(VW'(side_d_ff[QB].cx));
      vy   = ((side_d_ff[QB].negy ^ side_d_ff[QB].dneg) ? -qys : qys)
             + signed'(VW'(side_d_ff[QB].cy));
      satx = (vx > MAXV) || (vx < MINV);
      saty = (vy > MAXV) || (vy < MINV);
      if (side_d_ff[QB].zero) begin
         rsp_x_in     = '0;
         rsp_y_in     = '0;
         rsp_front_in = 1'b0;
         rsp_clip_in  = 1'b0;
      end else begin
         rsp_x_in     = (vx > MAXV) ? SWB'(MAXV) : (vx < MINV) ? SWB'(MINV) : SWB'(vx);
         rsp_y_in     = (vy > MAXV) ? SWB'(MAXV) : (vy < MINV) ? SWB'(MINV) : SWB'(vy);
         rsp_front_in = !side_d_ff[QB].dneg;
         rsp_clip_in  = satx || saty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_d_ff[QB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_front_ff <= rsp_front_in;
         rsp_clip_ff  <= rsp_clip_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;
   assign rsp_in_front = rsp_front_ff;
   assign rsp_clipped  = rsp_clip_ff;

   // The whole pipeline holds exactly when the output word is stalled.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("pipeline advances while the output word is stalled");

   // An accepted word enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> side1_ff.valid)
      else $error("accepted word was lost at the first stage");

   // A word with zero depth leaves as all zeros.
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (en && side_d_ff[QB].valid && side_d_ff[QB].zero) |=>
         (rsp_x_ff == '0) && (rsp_y_ff == '0) && !rsp_clip_ff && !rsp_front_ff)
      else $error("zero depth gave a nonzero result");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for perspective_screen_projection: random bursts of 3D
// points, a built-in projection predictor and an in-order result check.
// Depends on psp_pkg and the perspective_screen_projection RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] depth;
      logic signed [31:0] horiz;
      logic signed [31:0] vert;
   } point_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               in_front;
      logic               clipped;
   } pixel_type;

   localparam int PHASES = 8;
   localparam int POINTS_PER_PHASE = 230;
   localparam int LATENCY = 21;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [31:0] req_point_depth, req_point_horizontal, req_point_vertical;
   logic signed [15:0] rsp_screen_x, rsp_screen_y;
   logic rsp_in_front, rsp_clipped;
   logic csr_we;
   logic [psp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [psp_pkg::CSR_W-1:0] csr_wdata;

   point_type pending_points[$];
   pixel_type expected_pixels[$];
   logic [15:0] cur_focal;
   logic [12:0] cur_width, cur_height;
   logic hold_sender;
   int stall_requests, stall_served;
   int burst_left, gap_left;
   int stall_left, rx_mode, rx_mode_left;
   int idle_cycles;
   int errors;

   perspective_screen_projection dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [15:0] project_axis(logic [32:0] dmag, logic dneg,
         logic signed [31:0] lat, logic [12:0] size, logic [15:0] focal, ref logic sat);
      logic [127:0] num, den, quot;
      logic [32:0] lmag;
      logic lneg;
      longint v;
      lneg = lat[31];
      lmag = lneg ? 33'(-$signed({1'b1, lat})) : {1'b0, lat};
      num = 128'(lmag) * 128'(focal * 64'(size));
      den = 128'(dmag) << 10;
      quot = num / den;
      if (quot > (128'd1 << 40))
         quot = 128'd1 << 40;
      v = longint'(quot[63:0]);
      if (lneg != dneg)
         v = -v;
      v += longint'(size >> 1);
      if (v > 32767) begin
         v = 32767;
         sat = 1;
      end else if (v < -32768) begin
         v = -32768;
         sat = 1;
      end
      return v[15:0];
   endfunction

   function automatic pixel_type project_point(point_type p);
      pixel_type r;
      logic [32:0] dmag;
      logic dneg, sat;
      dneg = p.depth[31];
      dmag = dneg ? 33'(-$signed({1'b1, p.depth})) : {1'b0, p.depth};
      sat = 0;
      r = '{x: 0, y: 0, in_front: 0, clipped: 0};
      if (dmag != 0) begin
         r.x = project_axis(dmag, dneg, p.horiz, cur_width, cur_focal, sat);
         r.y = project_axis(dmag, dneg, p.vert, cur_height, cur_focal, sat);
         r.in_front = !dneg;
         r.clipped = sat;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] scaled_random();
      return $signed($urandom) >>> $urandom_range(0, 31);
   endfunction

   function automatic point_type random_point();
      point_type p;
      int kind;
      kind = $urandom_range(0, 9);
      p.horiz = scaled_random();
      p.vert = scaled_random();
      case (kind)
         0, 1, 2, 3, 4, 5: begin
            p.depth = ($urandom & 32'h7fffffff) >> $urandom_range(0, 30);
            if (p.depth == 0)
               p.depth = 1;
            p.horiz = p.horiz >>> $urandom_range(0, 4);
            p.vert = p.vert >>> $urandom_range(0, 4);
         end
         6: begin
            p.depth = $urandom;
            p.horiz = $urandom;
            p.vert = $urandom;
         end
         7: p.depth = -(($urandom & 32'h7fffffff) >> $urandom_range(0, 30));
         8: p.depth = 0;
         default: p.depth = $urandom_range(1, 16);
      endcase
      return p;
   endfunction

   task automatic write_csr(logic [psp_pkg::CSR_IDX_W-1:0] idx,
         logic [psp_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         psp_pkg::CSR_FOCAL_SCALE: cur_focal = value;
         psp_pkg::CSR_SCREEN_WIDTH: cur_width = value[12:0];
         default: cur_height = value[12:0];
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic wait_drained();
      while (pending_points.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic add_point(logic signed [31:0] d, logic signed [31:0] h,
         logic signed [31:0] v);
      pending_points.push_back('{depth: d, horiz: h, vert: v});
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      point_type p;
      if (reset) begin
         req_valid <= 0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready)
            expected_pixels.push_back(project_point('{depth: req_point_depth,
               horiz: req_point_horizontal, vert: req_point_vertical}));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (!hold_sender && pending_points.size() > 0) begin
               p = pending_points.pop_front();
               req_point_depth <= p.depth;
               req_point_horizontal <= p.horiz;
               req_point_vertical <= p.vert;
               req_valid <= 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end else
                  burst_left--;
            end else
               req_valid <= 0;
         end
      end
   end

   // Receiver: changing stall pattern plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         stall_left = 0;
         stall_served = 0;
         rx_mode = 0;
         rx_mode_left = 0;
      end else begin
         if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            stall_left = 300;
         end
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 96);
         end else
            rx_mode_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else
            case (rx_mode)
               0: rsp_ready <= 1;
               1: rsp_ready <= $urandom_range(0, 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
      end
   end

   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected word x=%0d y=%0d", $realtime, rsp_screen_x,
               rsp_screen_y);
            errors++;
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_screen_x !== e.x) begin
               $display("%0t: screen_x expected %0d actual %0d", $realtime, e.x,
                  rsp_screen_x);
               errors++;
            end
            if (rsp_screen_y !== e.y) begin
               $display("%0t: screen_y expected %0d actual %0d", $realtime, e.y,
                  rsp_screen_y);
               errors++;
            end
            if (rsp_in_front !== e.in_front) begin
               $display("%0t: in_front expected %0b actual %0b", $realtime,
                  e.in_front, rsp_in_front);
               errors++;
            end
            if (rsp_clipped !== e.clipped) begin
               $display("%0t: clipped expected %0b actual %0b", $realtime,
                  e.clipped, rsp_clipped);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[perspective_screen_projection] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_point_depth = 0;
      req_point_horizontal = 0;
      req_point_vertical = 0;
      csr_we = 0;
      csr_index = psp_pkg::CSR_FOCAL_SCALE;
      csr_wdata = 0;
      hold_sender = 0;
      stall_requests = 0;
      errors = 0;
      idle_cycles = 0;
      cur_focal = psp_pkg::FOCAL_SCALE_RESET;
      cur_width = psp_pkg::SCREEN_WIDTH_RESET;
      cur_height = psp_pkg::SCREEN_HEIGHT_RESET;
      repeat (11) @(posedge clock);
      reset <= 0;

      add_point(32'sh0001_0000, 32'sh0000_8000, -32'sh0000_8000);
      add_point(0, 32'sh7fff_ffff, 32'sh8000_0000);
      add_point(0, 0, 0);
      add_point(-32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000);
      add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
      add_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
      add_point(32'sh7fff_ffff, 1, -1);
      add_point(1, 32'sh7fff_ffff, 32'sh8000_0000);
      add_point(1, 1, -1);
      add_point(1, 0, 0);
      add_point(-1, 32'sh8000_0000, 32'sh7fff_ffff);
      add_point(32'sh000a_0000, 32'sh0005_0000, -32'sh0005_0000);
      add_point(32'sh000a_0000, 32'sh00ff_0000, -32'sh00ff_0000);
      add_point(-32'sh000a_0000, -32'sh0005_0000, 32'sh0005_0000);
      add_point(32'sh0000_0100, 32'sh0000_1000, 32'sh0000_0010);
      add_point(32'sh8000_0001, 32'sh0001_0000, 32'sh0001_0000);
      add_point(32'shffff_ffff, 32'shffff_ffff, 32'sh0000_0001);
      add_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555);
      add_point(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            wait_drained();
            case (ph)
               1: begin
                  write_csr(psp_pkg::CSR_FOCAL_SCALE, 16'd0);
                  write_csr(psp_pkg::CSR_SCREEN_WIDTH, 16'd1);
                  write_csr(psp_pkg::CSR_SCREEN_HEIGHT, 16'd1);
               end
               2: begin
                  write_csr(psp_pkg::CSR_FOCAL_SCALE, 16'hffff);
                  write_csr(psp_pkg::CSR_SCREEN_WIDTH, 16'd4096);
                  write_csr(psp_pkg::CSR_SCREEN_HEIGHT, 16'd4096);
               end
               3: begin
                  write_csr(psp_pkg::CSR_FOCAL_SCALE, 16'd1024);
                  write_csr(psp_pkg::CSR_SCREEN_WIDTH, 16'd4096);
                  write_csr(psp_pkg::CSR_SCREEN_HEIGHT, 16'd1);
               end
               default: begin
                  write_csr(psp_pkg::CSR_FOCAL_SCALE, 16'($urandom_range(0, 65535)));
                  write_csr(psp_pkg::CSR_SCREEN_WIDTH, 16'($urandom_range(1, 4096)));
                  write_csr(psp_pkg::CSR_SCREEN_HEIGHT, 16'($urandom_range(1, 4096)));
               end
            endcase
         end
         for (int i = 0; i < POINTS_PER_PHASE; i++)
            pending_points.push_back(random_point());
         if (ph == 2) begin
            repeat (50) @(posedge clock);
            stall_requests++;
         end
         if (ph == 4) begin
            while (pending_points.size() > POINTS_PER_PHASE / 2)
               @(posedge clock);
            hold_sender = 1;
            while (req_valid || expected_pixels.size() != 0)
               @(posedge clock);
            hold_sender = 0;
         end
      end

      wait_drained();
      if (errors == 0)
         $display("[perspective_screen_projection] OK");
      else
         $display("[perspective_screen_projection] ERROR");
      $finish;
   end
endmodule
